>>> sv/iu2x_pkg.sv
package iu2x_pkg;

  localparam int PIX_W       = 8;
  localparam int DIM_W       = 11;
  localparam int COORD_W     = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // One source pixel, classified and with all candidate output values worked out.
  typedef struct packed {
    logic [COORD_W-1:0] row2;      // twice the source row
    logic [COORD_W-1:0] col2;      // twice the source column
    logic               above_ok;  // a source row lies above
    logic               left_ok;   // a source column lies to the left
    logic               col_end;   // last source column
    logic               row_end;   // last source row
    logic [PIX_W-1:0]   odd_mid;   // odd row, odd column
    logic [PIX_W-1:0]   odd_here;  // odd row, even column
    logic [PIX_W-1:0]   cur_mid;   // even row, odd column
    logic [PIX_W-1:0]   pixel;     // even row, even column
  } job_t;

  typedef enum logic [2:0] {
    ROW_ABOVE = 3'b001,
    ROW_HERE  = 3'b010,
    ROW_BELOW = 3'b100
  } row_ph_t;

  typedef enum logic [2:0] {
    COL_LEFT  = 3'b001,
    COL_HERE  = 3'b010,
    COL_RIGHT = 3'b100
  } col_ph_t;

endpackage

>>> sv/iu2x_front.sv
module iu2x_front #(
  parameter int MAX_WIDTH  = iu2x_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iu2x_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iu2x_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iu2x_pkg::DIM_W-1:0]       cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [iu2x_pkg::PIX_W-1:0]       pixel_value,
  input  logic                             q_full,
  output logic                             push,
  output iu2x_pkg::job_t                   job
);
  import iu2x_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  function automatic logic [CW-1:0] width_last(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      return CW'(MAX_WIDTH - 1);
    end else begin
      return CW'(v - 1'b1);
    end
  endfunction

  function automatic logic [RW-1:0] height_last(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      return RW'(MAX_HEIGHT - 1);
    end else begin
      return RW'(v - 1'b1);
    end
  endfunction

  logic [CW-1:0]    w_last;
  logic [RW-1:0]    h_last;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [PIX_W-1:0] line_buffer [MAX_WIDTH];
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] above_left_pixel;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_pixel;
  logic [COORD_W-1:0] s1_row2;
  logic [COORD_W-1:0] s1_col2;
  logic               s1_above_ok;
  logic               s1_left_ok;
  logic               s1_col_end;
  logic               s1_row_end;

  logic             accept;
  logic [PIX_W:0]   cur_sum;
  logic [PIX_W:0]   above_sum;
  logic [PIX_W:0]   odd_sum;
  logic [PIX_W:0]   vert_sum;
  logic [PIX_W-1:0] cur_mid;
  logic [PIX_W-1:0] above_mid;

  assign cfg_ready   = 1'b1;
  assign pixel_ready = !s1_valid || !q_full;
  assign accept      = pixel_valid && pixel_ready;
  assign push        = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= '0;
      h_last <= '0;
      col    <= '0;
      row    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_last <= width_last(cfg_data);
        REG_IMAGE_HEIGHT: h_last <= height_last(cfg_data);
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Read-first port: the old entry is the pixel one row up at this column.
  always_ff @(posedge clk) begin
    if (accept) begin
      above            <= line_buffer[col];
      line_buffer[col] <= pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel    <= pixel_value;
      s1_row2     <= COORD_W'({row, 1'b0});
      s1_col2     <= COORD_W'({col, 1'b0});
      s1_above_ok <= (row != '0);
      s1_left_ok  <= (col != '0);
      s1_col_end  <= (col == w_last);
      s1_row_end  <= (row == h_last);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      above_left_pixel <= '0;
    end else if (push) begin
      left_pixel       <= s1_pixel;
      above_left_pixel <= above;
    end
  end

  always_comb begin
    cur_sum   = {1'b0, left_pixel} + {1'b0, s1_pixel};
    above_sum = {1'b0, above_left_pixel} + {1'b0, above};
    cur_mid   = cur_sum[PIX_W:1];
    above_mid = above_sum[PIX_W:1];
    odd_sum   = {1'b0, above_mid} + {1'b0, cur_mid};
    vert_sum  = {1'b0, above} + {1'b0, s1_pixel};

    job.row2     = s1_row2;
    job.col2     = s1_col2;
    job.above_ok = s1_above_ok;
    job.left_ok  = s1_left_ok;
    job.col_end  = s1_col_end;
    job.row_end  = s1_row_end;
    job.odd_mid  = odd_sum[PIX_W:1];
    job.odd_here = vert_sum[PIX_W:1];
    job.cur_mid  = cur_mid;
    job.pixel    = s1_pixel;
  end

endmodule

>>> sv/iu2x_queue.sv
module iu2x_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iu2x_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output iu2x_pkg::job_t head
);
  import iu2x_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

>>> sv/iu2x_back.sv
module iu2x_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  iu2x_pkg::job_t               job,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [iu2x_pkg::COORD_W-1:0] out_row,
  output logic [iu2x_pkg::COORD_W-1:0] out_col,
  output logic [iu2x_pkg::PIX_W-1:0]   out_value,
  output logic                         run_last
);
  import iu2x_pkg::*;

  logic    active;
  row_ph_t row_ph;
  col_ph_t col_ph;

  row_ph_t cur_row;
  col_ph_t cur_col;
  col_ph_t first_col;
  row_ph_t next_row;
  col_ph_t next_col;
  logic    has_next_row;
  logic    row_done;
  logic    job_done;
  logic    load;

  logic [COORD_W-1:0] row_n;
  logic [COORD_W-1:0] col_n;
  logic [PIX_W-1:0]   value_n;

  always_comb begin
    first_col = job.left_ok ? COL_LEFT : COL_HERE;
    cur_row   = active ? row_ph : (job.above_ok ? ROW_ABOVE : ROW_HERE);
    cur_col   = active ? col_ph : first_col;

    row_done = (cur_col == COL_RIGHT) || ((cur_col == COL_HERE) && !job.col_end);
    next_col = (cur_col == COL_LEFT) ? COL_HERE : COL_RIGHT;

    case (cur_row)
      ROW_ABOVE: begin
        has_next_row = 1'b1;
        next_row     = ROW_HERE;
        row_n        = job.row2 - 1'b1;
      end
      ROW_HERE: begin
        has_next_row = job.row_end;
        next_row     = ROW_BELOW;
        row_n        = job.row2;
      end
      default: begin
        has_next_row = 1'b0;
        next_row     = ROW_BELOW;
        row_n        = job.row2 + 1'b1;
      end
    endcase

    case (cur_col)
      COL_LEFT:  col_n = job.col2 - 1'b1;
      COL_HERE:  col_n = job.col2;
      default:   col_n = job.col2 + 1'b1;
    endcase

    if (cur_row == ROW_ABOVE) begin
      value_n = (cur_col == COL_LEFT) ? job.odd_mid : job.odd_here;
    end else begin
      value_n = (cur_col == COL_LEFT) ? job.cur_mid : job.pixel;
    end

    job_done = row_done && !has_next_row;
    load     = job_valid && (!out_valid || out_ready);
    pop      = load && job_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row_ph <= ROW_HERE;
      col_ph <= COL_HERE;
    end else if (load) begin
      if (job_done) begin
        active <= 1'b0;
      end else begin
        active <= 1'b1;
        if (row_done) begin
          row_ph <= next_row;
          col_ph <= first_col;
        end else begin
          row_ph <= cur_row;
          col_ph <= next_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row   <= row_n;
      out_col   <= col_n;
      out_value <= value_n;
      run_last  <= job_done;
    end
  end

endmodule

>>> sv/image_upscale_2x_interpolate.sv
// Streaming 2x image upscaler. Source pixels arrive in row-major order and
// each one produces the 1 to 9 output beats that it completes, tagged with
// their row and column in the doubled image; run_last marks the final beat
// of each source pixel. Over a whole image the average is four beats per
// source pixel, and the output side sends one beat per cycle while jobs are
// waiting and out_ready is high. The front end reads the previous source
// row from a line buffer (one read-first RAM port) and hands finished jobs
// through a four-entry queue, so it keeps taking pixels while a long job
// drains; an accepted pixel passes the front stage register, a queue slot
// and the output register before its first beat is presented. A write to
// either size register restarts the image at its top-left pixel; a size of
// 0 acts as 1 and an oversize value acts as the maximum. Registers must only
// be written while no output is pending.
module image_upscale_2x_interpolate #(
  parameter int MAX_WIDTH  = iu2x_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = iu2x_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iu2x_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iu2x_pkg::DIM_W-1:0]       cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [iu2x_pkg::PIX_W-1:0]       pixel_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [iu2x_pkg::COORD_W-1:0]     out_row,
  output logic [iu2x_pkg::COORD_W-1:0]     out_col,
  output logic [iu2x_pkg::PIX_W-1:0]       out_value,
  output logic                             run_last
);
  import iu2x_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic head_valid;
  job_t push_job;
  job_t head;

  iu2x_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_value (pixel_value),
    .q_full      (q_full),
    .push        (push),
    .job         (push_job)
  );

  iu2x_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  iu2x_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .run_last  (run_last)
  );

`ifndef SYNTHESIS
  // A job leaves the queue only with the beat that closes its pixel.
  a_pop_closes_pixel: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && run_last))
    else $error("job retired without a closing beat");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // The input stalls only while the front stage waits on a full queue.
  a_stall_on_full: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (q_full && !push))
    else $error("pixel input stalled while the queue has room");
`endif

endmodule
